@@ rtl/dbot_pkg.sv @@
`default_nettype none

package dbot_pkg;

  // Fixed field widths
  localparam int ADDR_W  = 48;
  localparam int CYCLE_W = 48;
  localparam int ROW_W   = 34;
  localparam int LAT_W   = 32;
  localparam int CNT_W   = 32;
  localparam int CFG_W   = 8;
  localparam int CFG_IDX_W = 2;
  localparam int COST_W  = CFG_W + 2;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CAS       = 2'd0,
    CFG_RAS       = 2'd1,
    CFG_PRECHARGE = 2'd2,
    CFG_BURST     = 2'd3
  } cfg_idx_t;

  // Reset values of the timing registers
  localparam logic [CFG_W-1:0] CAS_RESET       = 8'd14;
  localparam logic [CFG_W-1:0] RAS_RESET       = 8'd14;
  localparam logic [CFG_W-1:0] PRECHARGE_RESET = 8'd14;
  localparam logic [CFG_W-1:0] BURST_RESET     = 8'd8;

  // One entry of the bank state memory
  typedef struct packed {
    logic [CYCLE_W-1:0] ready;
    logic [ROW_W-1:0]   row;
  } bank_entry_t;

  // Controller states
  typedef enum logic [3:0] {
    S_CLEAR  = 4'b0001,
    S_IDLE   = 4'b0010,
    S_LOOKUP = 4'b0100,
    S_UPDATE = 4'b1000
  } state_t;

  // Field width of a non-power-of-two size rounds down
  function automatic int floor_log2(input int v);
    int n;
    int x;
    n = 0;
    x = v;
    while (x > 1) begin
      x = x >> 1;
      n = n + 1;
    end
    return n;
  endfunction

endpackage

`default_nettype wire

@@ rtl/dbot_ram.sv @@
`default_nettype none

module dbot_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ rtl/dbot_decode.sv @@
`default_nettype none

module dbot_decode #(
  parameter int CHANNELS         = 2,
  parameter int BANKS            = 8,
  parameter int LINE_BYTES       = 64,
  parameter int ROW_BUFFER_BYTES = 1024,
  parameter int ADDRESS_BITS     = 48,
  parameter int CH_W             = 1,
  parameter int AW               = 4
) (
  input  wire logic [dbot_pkg::ADDR_W-1:0] address,
  output logic      [CH_W-1:0]             channel,
  output logic      [AW-1:0]               gbank,
  output logic      [dbot_pkg::ROW_W-1:0]  row
);

  import dbot_pkg::*;

  localparam int LINE_BITS  = floor_log2(LINE_BYTES);
  localparam int COL_BITS   = floor_log2(ROW_BUFFER_BYTES / LINE_BYTES);
  localparam int BANK_BITS  = floor_log2(BANKS);
  localparam int CHAN_SHIFT = LINE_BITS;
  localparam int BANK_SHIFT = CHAN_SHIFT + CH_W + COL_BITS;
  localparam int ROW_SHIFT  = BANK_SHIFT + BANK_BITS;

  localparam logic [ADDR_W-1:0] ADDR_MASK =
    (ADDRESS_BITS >= ADDR_W) ? {ADDR_W{1'b1}}
                             : ((ADDR_W'(1) << ADDRESS_BITS) - ADDR_W'(1));
  localparam logic [ADDR_W-1:0] BANK_MASK = (ADDR_W'(1) << BANK_BITS) - ADDR_W'(1);

  logic [ADDR_W-1:0] addr;
  logic [ADDR_W-1:0] chan_bits;
  logic [ADDR_W-1:0] bank_bits;
  logic [AW-1:0]     chan_ext;
  logic [AW-1:0]     bank;

  // Byte-in-line, channel, column, bank, row from low to high
  always_comb begin
    addr      = address & ADDR_MASK;
    chan_bits = addr >> CHAN_SHIFT;
    bank_bits = (addr >> BANK_SHIFT) & BANK_MASK;
    channel   = chan_bits[CH_W-1:0];
    chan_ext  = AW'(channel);
    bank      = bank_bits[AW-1:0];
    gbank     = chan_ext * AW'(BANKS) + bank;
    row       = ROW_W'(addr >> ROW_SHIFT);
  end

endmodule

`default_nettype wire

@@ rtl/dram_bank_open_row_timing.sv @@
`default_nettype none
// Flow: an accepted request passes the bank read (S_LOOKUP) and the cost stage
// (S_UPDATE); write-back and result load happen on the same edge.
// Throughput: no new request is taken until the read-modify-write of the bank
// state memory is written back; a stalled result holds the write-back until taken.
// Reset: synchronous; timing registers return to their defaults, counters clear, and
// a sweep over all CHANNELS*BANKS entries zeroes the bank memory with in_stall high.
module dram_bank_open_row_timing #(
  parameter int CHANNELS         = 2,
  parameter int BANKS            = 8,
  parameter int LINE_BYTES       = 64,
  parameter int ROW_BUFFER_BYTES = 1024,
  parameter int ADDRESS_BITS     = 48
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // configuration
  input  wire logic                          cfg_write,
  input  wire logic [dbot_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [dbot_pkg::CFG_W-1:0]    cfg_data,
  // request
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [dbot_pkg::ADDR_W-1:0]   address,
  input  wire logic [dbot_pkg::CYCLE_W-1:0]  current_cycle,
  // result
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic      [dbot_pkg::LAT_W-1:0]    latency,
  output logic                               row_hit,
  output logic                               channel_index,
  output logic      [3:0]                    bank_index,
  output logic      [dbot_pkg::ROW_W-1:0]    row_number,
  output logic      [dbot_pkg::CNT_W-1:0]    hit_total,
  output logic      [dbot_pkg::CNT_W-1:0]    miss_total
);

  import dbot_pkg::*;

  localparam int NUM_BANKS = CHANNELS * BANKS;
  localparam int AW        = $clog2(NUM_BANKS);
  localparam int CH_W      = floor_log2(CHANNELS);
  localparam int GBX       = (AW > 4) ? AW : 4;
  localparam int ENTRY_W   = $bits(bank_entry_t);

  state_t state, state_next;

  // timing registers
  logic [CFG_W-1:0] cas_latency, ras_latency, precharge_latency, burst_latency;

  // request registers
  logic [CH_W-1:0]    req_channel;
  logic [AW-1:0]      req_gbank;
  logic [ROW_W-1:0]   req_row;
  logic [CYCLE_W-1:0] req_now;

  // lookup results
  logic               hit_q;
  logic [COST_W-1:0]  cost_q;
  logic [CYCLE_W-1:0] base_q;
  logic [CYCLE_W-1:0] wait_q;

  logic [CNT_W-1:0] hit_counter, miss_counter;
  logic [CNT_W-1:0] hit_counter_next, miss_counter_next;
  logic [AW-1:0]    clr_idx;

  // decoded request fields
  logic [CH_W-1:0]  dec_channel;
  logic [AW-1:0]    dec_gbank;
  logic [ROW_W-1:0] dec_row;

  // memory port
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;
  bank_entry_t      rd_entry;

  // datapath
  logic               lk_hit;
  logic               lk_busy;
  logic [COST_W-1:0]  lk_cost;
  logic [CYCLE_W:0]   ready_sum;
  logic [CYCLE_W-1:0] new_ready;
  logic [CYCLE_W:0]   lat_sum;
  logic [LAT_W-1:0]   lat_val;
  logic [GBX-1:0]     gbank_ext;
  logic               out_free;
  logic               accept;
  logic               finish;

  dbot_decode #(
    .CHANNELS        (CHANNELS),
    .BANKS           (BANKS),
    .LINE_BYTES      (LINE_BYTES),
    .ROW_BUFFER_BYTES(ROW_BUFFER_BYTES),
    .ADDRESS_BITS    (ADDRESS_BITS),
    .CH_W            (CH_W),
    .AW              (AW)
  ) u_decode (
    .address(address),
    .channel(dec_channel),
    .gbank  (dec_gbank),
    .row    (dec_row)
  );

  dbot_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(NUM_BANKS)
  ) u_bank_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(dec_gbank),
    .rdata(ram_rdata)
  );

  // handshakes
  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign finish   = (state == S_UPDATE) && out_free;

  // lookup: hit check, access cost, wait behind a busy bank
  always_comb begin
    rd_entry = bank_entry_t'(ram_rdata);
    lk_hit   = (rd_entry.row == req_row);
    lk_cost  = lk_hit ? COST_W'(cas_latency)
                      : COST_W'(cas_latency) + COST_W'(ras_latency)
                        + COST_W'(precharge_latency);
    lk_busy  = (req_now < rd_entry.ready);
  end

  // update: new ready cycle, latency, counters
  always_comb begin
    ready_sum = {1'b0, base_q} + (CYCLE_W+1)'(cost_q);
    new_ready = ready_sum[CYCLE_W] ? {CYCLE_W{1'b1}} : ready_sum[CYCLE_W-1:0];
    lat_sum   = {1'b0, wait_q} + (CYCLE_W+1)'(cost_q) + (CYCLE_W+1)'(burst_latency);
    lat_val   = (|lat_sum[CYCLE_W:LAT_W]) ? {LAT_W{1'b1}} : lat_sum[LAT_W-1:0];
    hit_counter_next  = hit_counter;
    miss_counter_next = miss_counter;
    if (hit_q) begin
      if (hit_counter != {CNT_W{1'b1}}) hit_counter_next = hit_counter + CNT_W'(1);
    end else begin
      if (miss_counter != {CNT_W{1'b1}}) miss_counter_next = miss_counter + CNT_W'(1);
    end
    gbank_ext = GBX'(req_gbank);
  end

  // memory write: clearing sweep or bank write-back
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = req_gbank;
    ram_wdata = {new_ready, req_row};
    if (state == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_idx;
      ram_wdata = '0;
    end else if (finish) begin
      ram_we    = 1'b1;
    end
  end

  // controller
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (clr_idx == AW'(NUM_BANKS - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (accept) state_next = S_LOOKUP;
      end
      S_LOOKUP: begin
        state_next = S_UPDATE;
      end
      S_UPDATE: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_idx <= '0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) clr_idx <= clr_idx + AW'(1);
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cas_latency       <= CAS_RESET;
      ras_latency       <= RAS_RESET;
      precharge_latency <= PRECHARGE_RESET;
      burst_latency     <= BURST_RESET;
    end else if (cfg_write) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_CAS:       cas_latency       <= cfg_data;
        CFG_RAS:       ras_latency       <= cfg_data;
        CFG_PRECHARGE: precharge_latency <= cfg_data;
        CFG_BURST:     burst_latency     <= cfg_data;
        default: ;
      endcase
    end
  end

  // request capture and lookup registers
  always_ff @(posedge clk) begin
    if (accept) begin
      req_channel <= dec_channel;
      req_gbank   <= dec_gbank;
      req_row     <= dec_row;
      req_now     <= current_cycle;
    end
    if (state == S_LOOKUP) begin
      hit_q  <= lk_hit;
      cost_q <= lk_cost;
      base_q <= lk_busy ? rd_entry.ready : req_now;
      wait_q <= lk_busy ? (rd_entry.ready - req_now) : '0;
    end
  end

  // counters
  always_ff @(posedge clk) begin
    if (rst) begin
      hit_counter  <= '0;
      miss_counter <= '0;
    end else if (finish) begin
      hit_counter  <= hit_counter_next;
      miss_counter <= miss_counter_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      latency       <= lat_val;
      row_hit       <= hit_q;
      channel_index <= req_channel[0];
      bank_index    <= gbank_ext[3:0];
      row_number    <= req_row;
      hit_total     <= hit_counter_next;
      miss_total    <= miss_counter_next;
    end
  end

endmodule

`default_nettype wire

@@ verif/dram_bank_open_row_timing_tb.sv @@
module dram_bank_open_row_timing_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dbot_pkg::*;

  localparam int QUIET_LIMIT      = 5000;
  localparam int PHASE_REQUESTS   = 333;
  localparam int HOLD_OFF_CYCLES  = 300;
  localparam int DRAIN_CYCLES     = 4;
  localparam int NUM_GBANKS       = 16;

  // One result of the block, field for field
  typedef struct {
    logic [LAT_W-1:0] lat;
    logic             hit;
    logic             chan;
    logic [3:0]       gbank;
    logic [ROW_W-1:0] row;
    logic [CNT_W-1:0] hits;
    logic [CNT_W-1:0] misses;
  } access_result_t;

  // Open-page bank model plus the queue of results still to come
  class bank_timing_scoreboard;
    logic [CFG_W-1:0]   t_cas, t_ras, t_rp, t_burst;
    logic [CYCLE_W-1:0] ready_at [NUM_GBANKS];
    logic [ROW_W-1:0]   open_row [NUM_GBANKS];
    logic [CNT_W-1:0]   hit_count, miss_count;
    access_result_t     pending_results [$];
    int                 errors;

    function new();
      t_cas   = CAS_RESET;
      t_ras   = RAS_RESET;
      t_rp    = PRECHARGE_RESET;
      t_burst = BURST_RESET;
      foreach (ready_at[i]) begin
        ready_at[i] = '0;
        open_row[i] = '0;
      end
      hit_count  = '0;
      miss_count = '0;
      errors     = 0;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [CFG_W-1:0] val);
      case (idx)
        CFG_CAS:       t_cas = val;
        CFG_RAS:       t_ras = val;
        CFG_PRECHARGE: t_rp = val;
        CFG_BURST:     t_burst = val;
        default: ;
      endcase
    endfunction

    // Bank lookup, cost, and state update for one request
    function access_result_t predict_access(logic [ADDR_W-1:0] addr, logic [CYCLE_W-1:0] now);
      access_result_t r;
      logic [3:0]       g;
      logic [ROW_W-1:0] row;
      logic [9:0]       cost;
      logic [48:0]      next_ready;
      logic [48:0]      bank_wait;
      logic [49:0]      total;
      logic             hit;
      row  = addr[47:14];
      g    = {addr[6], addr[13:11]};
      hit  = (row == open_row[g]);
      cost = hit ? 10'(t_cas) : 10'(t_cas) + 10'(t_ras) + 10'(t_rp);
      if (now >= ready_at[g]) begin
        bank_wait  = '0;
        next_ready = 49'(now) + 49'(cost);
      end else begin
        bank_wait  = 49'(ready_at[g] - now);
        next_ready = 49'(ready_at[g]) + 49'(cost);
      end
      ready_at[g] = next_ready[48] ? '1 : next_ready[47:0];
      if (!hit) open_row[g] = row;
      total = 50'(t_burst) + 50'(bank_wait) + 50'(cost);
      if (hit) begin
        if (hit_count != '1) hit_count++;
      end else begin
        if (miss_count != '1) miss_count++;
      end
      r.lat    = (total > 50'hFFFF_FFFF) ? '1 : total[31:0];
      r.hit    = hit;
      r.chan   = addr[6];
      r.gbank  = g;
      r.row    = row;
      r.hits   = hit_count;
      r.misses = miss_count;
      return r;
    endfunction

    function void note_request(logic [ADDR_W-1:0] addr, logic [CYCLE_W-1:0] now);
      pending_results.push_back(predict_access(addr, now));
    endfunction

    function void compare_field(string name, logic [63:0] e, logic [63:0] a);
      if (e !== a) begin
        errors++;
        $display("%0t mismatch %s expected %0h actual %0h", $time, name, e, a);
      end
    endfunction

    function void check_result(access_result_t act);
      access_result_t e;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t result with no request pending: latency %0h bank %0h",
                 $time, act.lat, act.gbank);
        return;
      end
      e = pending_results.pop_front();
      compare_field("latency", 64'(e.lat), 64'(act.lat));
      compare_field("row_hit", 64'(e.hit), 64'(act.hit));
      compare_field("channel_index", 64'(e.chan), 64'(act.chan));
      compare_field("bank_index", 64'(e.gbank), 64'(act.gbank));
      compare_field("row_number", 64'(e.row), 64'(act.row));
      compare_field("hit_total", 64'(e.hits), 64'(act.hits));
      compare_field("miss_total", 64'(e.misses), 64'(act.misses));
    endfunction

    function int pending();
      return pending_results.size();
    endfunction
  endclass

  logic                 clk;
  logic                 rst;
  logic                 cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  logic                 in_valid;
  logic                 in_stall;
  logic [ADDR_W-1:0]    address;
  logic [CYCLE_W-1:0]   current_cycle;
  logic                 out_valid;
  logic                 out_stall;
  logic [LAT_W-1:0]     latency;
  logic                 row_hit;
  logic                 channel_index;
  logic [3:0]           bank_index;
  logic [ROW_W-1:0]     row_number;
  logic [CNT_W-1:0]     hit_total;
  logic [CNT_W-1:0]     miss_total;

  bank_timing_scoreboard sb;
  int                    tx_pct;
  int                    rx_pct;
  logic                  hold_req;
  logic                  hold_off;
  int                    quiet_cycles;
  logic [CYCLE_W-1:0]    cycle_base;
  logic [ROW_W-1:0]      row_pool [4];

  dram_bank_open_row_timing u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .address       (address),
    .current_cycle (current_cycle),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .latency       (latency),
    .row_hit       (row_hit),
    .channel_index (channel_index),
    .bank_index    (bank_index),
    .row_number    (row_number),
    .hit_total     (hit_total),
    .miss_total    (miss_total)
  );

  always #2 clk = ~clk;

  // Address layout: row | bank(3) | column(4) | channel | byte(6)
  function automatic logic [ADDR_W-1:0] make_address(logic chan, logic [2:0] bnk,
                                                     logic [ROW_W-1:0] row);
    logic [3:0] col;
    logic [5:0] byte_off;
    col      = 4'($urandom);
    byte_off = 6'($urandom);
    return {row, bnk, col, chan, byte_off};
  endfunction

  // Offer one request and hold it until taken
  task automatic send_request(logic [ADDR_W-1:0] a, logic [CYCLE_W-1:0] c);
    while ($urandom_range(0, 99) < tx_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    address       <= a;
    current_cycle <= c;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_request(a, c);
  endtask

  task automatic send_random();
    logic [ADDR_W-1:0]  a;
    logic [CYCLE_W-1:0] c;
    // mostly requests into a few rows per bank, the rest anywhere
    if ($urandom_range(0, 99) < 75)
      a = make_address(1'($urandom), 3'($urandom), row_pool[$urandom_range(0, 3)]);
    else
      a = 48'({$urandom, $urandom});
    if ($urandom_range(0, 99) < 2) begin
      c = 48'({$urandom, $urandom});
    end else begin
      cycle_base = cycle_base + 48'($urandom_range(0, 15));
      c = cycle_base;
    end
    send_request(a, c);
  endtask

  // Write all four timing registers back to back
  task automatic write_timing(logic [CFG_W-1:0] cas, logic [CFG_W-1:0] ras,
                              logic [CFG_W-1:0] rp, logic [CFG_W-1:0] burst);
    logic [CFG_W-1:0] vals [4];
    vals[0] = cas;
    vals[1] = ras;
    vals[2] = rp;
    vals[3] = burst;
    cfg_write <= 1'b1;
    for (int i = 0; i < 4; i++) begin
      cfg_index <= CFG_IDX_W'(i);
      cfg_data  <= vals[i];
      @(posedge clk);
      sb.set_reg(cfg_idx_t'(i), vals[i]);
    end
    cfg_write <= 1'b0;
  endtask

  task automatic drain();
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Result side: check what is taken, then pick the next stall
  always @(posedge clk) begin
    access_result_t act;
    if (rst === 1'b0 && out_valid === 1'b1 && out_stall === 1'b0) begin
      act.lat    = latency;
      act.hit    = row_hit;
      act.chan   = channel_index;
      act.gbank  = bank_index;
      act.row    = row_number;
      act.hits   = hit_total;
      act.misses = miss_total;
      sb.check_result(act);
    end
    out_stall <= hold_off || ($urandom_range(0, 99) < rx_pct);
  end

  // Long receiver hold-off so the block backs up into its input
  initial begin
    hold_off = 1'b0;
    while (hold_req !== 1'b1) @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_OFF_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  // Cycles without any transfer on either side
  always @(posedge clk) begin
    if ((in_valid === 1'b1 && in_stall === 1'b0) || (out_valid === 1'b1 && out_stall === 1'b0))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    clk           = 1'b0;
    rst           = 1'b1;
    cfg_write     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    in_valid      = 1'b0;
    address       = '0;
    current_cycle = '0;
    out_stall     = 1'b0;
    hold_req      = 1'b0;
    quiet_cycles  = 0;
    cycle_base    = '0;
    tx_pct        = 11;
    rx_pct        = 71;
    sb            = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed part at reset timing
    send_request(make_address(1'b0, 3'd0, '0), '0);           // fresh bank, row 0 hits
    send_request(make_address(1'b0, 3'd0, '0), '0);           // same bank still busy
    send_request(make_address(1'b0, 3'd0, 34'd1), 48'd5);     // row miss while busy
    send_request(make_address(1'b1, 3'd0, '0), 48'd100);      // channel 1, fresh bank
    for (int b = 1; b < 8; b++)
      send_request(make_address(1'b0, 3'(b), '1), 48'(200 + b));
    send_request('1, '1);                                     // ready cycle saturates
    send_request('1, '0);                                     // latency saturates
    send_request(make_address(1'b1, 3'd3, 34'h2_AAAA_AAAA), 48'h5555_5555_5555);
    send_request(make_address(1'b1, 3'd3, 34'h1_5555_5555), 48'hAAAA_AAAA_AAAA);
    send_request(make_address(1'b0, 3'd0, 34'd1), '0);
    send_request(make_address(1'b0, 3'd0, 34'd1), 48'd1);
    in_valid <= 1'b0;
    cycle_base = 48'd1000;

    // Random phases, each with its own timing setting
    for (int p = 0; p < 4; p++) begin
      drain();
      case (p)
        0: write_timing(8'd0, 8'd0, 8'd0, 8'd0);
        1: write_timing(8'hFF, 8'hFF, 8'hFF, 8'hFF);
        2: write_timing(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        default: write_timing(8'hFF, 8'($urandom), 8'd0, 8'hFF);
      endcase
      case (p)
        0: begin
          tx_pct = 11;
          rx_pct = 71;
        end
        1: begin
          tx_pct = 71;
          rx_pct = 11;
          cycle_base = 48'h0100_0000_0000 | 48'($urandom);
        end
        2: begin
          tx_pct = 0;
          rx_pct = 0;
          cycle_base = 48'h8000_0000_0000 + 48'($urandom);
        end
        default: begin
          tx_pct = 0;
          rx_pct = 0;
          cycle_base = 48'hFFFF_FFFF_FFFF - 48'd12000;
        end
      endcase
      row_pool[0] = '0;
      row_pool[1] = 34'({$urandom, $urandom});
      row_pool[2] = 34'({$urandom, $urandom});
      row_pool[3] = '1;
      if (p == 3) hold_req = 1'b1;
      repeat (PHASE_REQUESTS) send_random();
      in_valid <= 1'b0;
    end

    drain();
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

@@ files.f @@
rtl/dbot_pkg.sv
rtl/dbot_ram.sv
rtl/dbot_decode.sv
rtl/dram_bank_open_row_timing.sv
verif/dram_bank_open_row_timing_tb.sv
